[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every property is clocked on clk and
// is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

[rtl/b64enc_pkg.sv]
package b64enc_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int RPT_BITS = 32;

	// Configuration register indexes.
	localparam logic REG_LIMIT_ENABLE = 1'b0;
	localparam logic REG_BYTE_LIMIT = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='
	localparam logic [7:0] PLUS_CHAR = 8'h2b; // '+'
	localparam logic [7:0] SLASH_CHAR = 8'h2f; // '/'
	localparam logic [5:0] UPPER_END = 6'd26;
	localparam logic [5:0] LOWER_END = 6'd52;
	localparam logic [5:0] DIGIT_END = 6'd62;

	// One encoded group on its way to the output serializer.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic done;
		logic [RPT_BITS-1:0] count;
	} group_t;

	// Maps a six-bit value onto the standard alphabet.
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < UPPER_END) begin
			c = 8'h41 + 8'(v);
		end else if (v < LOWER_END) begin
			c = 8'h61 + 8'(v - UPPER_END);
		end else if (v < DIGIT_END) begin
			c = 8'h30 + 8'(v - LOWER_END);
		end else if (v == DIGIT_END) begin
			c = PLUS_CHAR;
		end else begin
			c = SLASH_CHAR;
		end
		return c;
	endfunction

endpackage

[rtl/b64enc_cfg.sv]
module b64enc_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	output logic        limit_enable,
	output logic [31:0] limit_round
);

	// Remainder modulo three: 4 = 1 (mod 3), so the two-bit digits are summed.
	function automatic logic [1:0] mod3(input logic [31:0] v);
		logic [3:0] bsum;
		logic [5:0] s;
		logic [3:0] s2;
		logic [2:0] s3;
		s = '0;
		for (int i = 0; i < 4; i++) begin
			bsum = '0;
			for (int j = 0; j < 4; j++) begin
				bsum = bsum + 4'(v[8*i+2*j +: 2]);
			end
			s = s + 6'(bsum);
		end
		s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
		s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
		return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
	endfunction

	logic        limit_enable_q;
	logic [31:0] limit_round_q;
	logic [31:0] rounded;

	// The limit is stored already rounded down to a multiple of three.
	assign rounded = cfg_wdata - 32'(mod3(cfg_wdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_enable_q <= 1'b0;
			limit_round_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				b64enc_pkg::REG_LIMIT_ENABLE: limit_enable_q <= cfg_wdata[0];
				b64enc_pkg::REG_BYTE_LIMIT: limit_round_q <= rounded;
				default: limit_enable_q <= limit_enable_q;
			endcase
		end
	end

	assign limit_enable = limit_enable_q;
	assign limit_round = limit_round_q;

endmodule

[rtl/b64enc_core.sv]
module b64enc_core #(
	parameter int COUNT_BITS = b64enc_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_eos,
	input  logic                limit_enable,
	input  logic [31:0]         limit_round,
	output logic                grp_valid,
	input  logic                grp_ready,
	output b64enc_pkg::group_t  grp
);

	localparam int RB = b64enc_pkg::RPT_BITS;
	localparam int CMP_BITS = (COUNT_BITS > RB) ? COUNT_BITS : RB;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eos_s1;
	logic [1:0]            held_count_q;
	logic [7:0]            held0_q;
	logic [7:0]            held1_q;
	logic [COUNT_BITS-1:0] total_q;

	logic                  drop;
	logic                  emits;
	logic                  advance;
	logic [COUNT_BITS:0]   total_inc;
	logic [COUNT_BITS-1:0] total_sat;
	logic [RB-1:0]         rpt;
	logic [7:0]            b1, b2, b3;

	assign drop = limit_enable && (CMP_BITS'(total_q) >= CMP_BITS'(limit_round));
	assign emits = eos_s1 ? (held_count_q != 2'd0) : (!drop && held_count_q == 2'd2);
	assign advance = valid_s1 && (!emits || grp_ready);
	assign in_ready = !valid_s1 || advance;
	assign grp_valid = valid_s1 && emits;

	assign total_inc = {1'b0, total_q} + (COUNT_BITS + 1)'(3);
	assign total_sat = total_inc[COUNT_BITS] ? '1 : total_inc[COUNT_BITS-1:0];

	if (COUNT_BITS > RB) begin : g_wide
		assign rpt = (|total_sat[COUNT_BITS-1:RB]) ? '1 : total_sat[RB-1:0];
	end else begin : g_narrow
		assign rpt = RB'(total_sat);
	end

	// A flush with one held byte has no second byte; the third byte only
	// exists when a data byte completes the group.
	assign b1 = held0_q;
	assign b2 = (held_count_q == 2'd2) ? held1_q : 8'd0;
	assign b3 = eos_s1 ? 8'd0 : byte_s1;

	always_comb begin
		grp.chars[0] = b64enc_pkg::sextet_char(b1[7:2]);
		grp.chars[1] = b64enc_pkg::sextet_char({b1[1:0], b2[7:4]});
		grp.chars[2] = (eos_s1 && held_count_q == 2'd1) ? b64enc_pkg::PAD_CHAR
			: b64enc_pkg::sextet_char({b2[3:0], b3[7:6]});
		grp.chars[3] = eos_s1 ? b64enc_pkg::PAD_CHAR : b64enc_pkg::sextet_char(b3[5:0]);
		grp.done = eos_s1;
		grp.count = rpt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			held_count_q <= 2'd0;
			total_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				priority if (eos_s1) begin
					held_count_q <= 2'd0;
					total_q <= '0;
				end else if (drop) begin
					held_count_q <= held_count_q;
				end else if (held_count_q == 2'd2) begin
					held_count_q <= 2'd0;
					total_q <= total_sat;
				end else begin
					held_count_q <= held_count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eos_s1 <= in_eos;
		end
		if (advance && !eos_s1 && !drop) begin
			if (held_count_q == 2'd0) begin
				held0_q <= byte_s1;
			end
			if (held_count_q == 2'd1) begin
				held1_q <= byte_s1;
			end
		end
	end

endmodule

[rtl/b64enc_serializer.sv]
module b64enc_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               grp_valid,
	output logic               grp_ready,
	input  b64enc_pkg::group_t grp,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	b64enc_pkg::group_t grp_q;
	logic               busy_q;
	logic [1:0]         idx_q;
	logic               take;
	logic               finishing;

	assign take = busy_q && m_tready;
	assign finishing = take && idx_q == 2'd3;
	assign grp_ready = !busy_q || finishing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (grp_valid && grp_ready) begin
			busy_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (take) begin
			busy_q <= !finishing;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			grp_q <= grp;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata = {grp_q.count, grp_q.chars[idx_q]};
	assign m_tlast = idx_q == 2'd3;
	assign m_tuser = grp_q.done && idx_q == 2'd3;

endmodule

[rtl/base64_stream_encoder_unit.sv]
// Base64 stream encoder (standard alphabet, '=' padding).
// Input stream: one transaction per byte; s_tdata carries the byte and
// s_tlast marks an end-of-stream transaction whose byte is ignored. Every
// third byte yields a group of four characters on the output stream, one
// per transaction. An end-of-stream transaction flushes one or two held
// bytes as a padded group, flagged on its fourth character by m_tuser, and
// then clears the running byte count; with nothing held it yields nothing.
// m_tlast marks the fourth character of every group, and m_tdata carries the
// running byte count, saturated, beside each character.
// The byte completing a group is loaded into the input register, and the
// group then into the group register once that register is free; the first
// character is presented from there. Bytes past an enabled byte limit
// are dropped. Throughput: a byte can be taken every cycle while the group
// register is free; a group holds the output for its four characters, so a
// sustained stream is limited by the one-character output port.
// A stalled receiver holds the current character; the input register still
// takes one more byte, and bytes that do not complete a group keep flowing.
// Reset clears the held byte count, the running count, the valid flags of
// both pipeline registers and both configuration registers.
`include "assert_macros.svh"

module base64_stream_encoder_unit #(
	parameter int COUNT_BITS = b64enc_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [7:0] encoded_char, [39:8] bytes_encoded
	output logic        m_tlast,  // group_last
	output logic        m_tuser,  // stream_done
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic               limit_enable;
	logic [31:0]        limit_round;
	logic               grp_valid;
	logic               grp_ready;
	b64enc_pkg::group_t grp;

	// Configuration registers; the limit is kept rounded to whole groups.
	b64enc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.limit_enable (limit_enable),
		.limit_round  (limit_round)
	);

	// Input register, byte holding, limit check and group encoding.
	b64enc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_byte      (s_tdata),
		.in_eos       (s_tlast),
		.limit_enable (limit_enable),
		.limit_round  (limit_round),
		.grp_valid    (grp_valid),
		.grp_ready    (grp_ready),
		.grp          (grp)
	);

	// Group register that hands out the four characters one at a time.
	b64enc_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// The stream end flag only ever rides on a group's closing character.
	`ASSERT_IMPL(a_done_on_last, m_tvalid && m_tuser, m_tlast)
	// A group handed over is presented on the output in the next cycle.
	`ASSERT_NEXT(a_group_shown, grp_valid && grp_ready, m_tvalid)
	// Without a new group, the output empties after a group's last character.
	`ASSERT_NEXT(a_group_drains, m_tvalid && m_tready && m_tlast && !grp_valid, !m_tvalid)

endmodule
